[hw/rtl/mccd_pkg.sv]
// Shared types, widths and result formatting for the min-coin change block.
package mccd_pkg;

    localparam int CV_W   = 10;  // coin, amount and count field width
    localparam int BEST_W = 11;  // table count field, holds count+1 (0 = unreachable)

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic KIND_TARGET = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic            action;
        logic [CV_W-1:0] coin_value;
        logic            last_coin;
        logic [CV_W-1:0] query_amount;
    } in_t;

    typedef struct packed {
        logic            result_kind;
        logic            reachable;
        logic [CV_W-1:0] coin_total;
        logic [CV_W-1:0] coin_used;
    } out_t;

    typedef struct packed {
        logic [BEST_W-1:0] best;
        logic [CV_W-1:0]   used;
    } tbl_entry_t;

    localparam int TBL_W = $bits(tbl_entry_t);

    function automatic out_t make_result(input logic kind, input tbl_entry_t e);
        out_t              r;
        logic [BEST_W-1:0] tot;
        tot           = e.best - BEST_W'(1);
        r.result_kind = kind;
        r.reachable   = (e.best != '0);
        if (e.best == '0) begin
            r.coin_total = '0;
        end else if (tot[BEST_W-1:CV_W] != '0) begin
            r.coin_total = '1;
        end else begin
            r.coin_total = tot[CV_W-1:0];
        end
        r.coin_used = e.used;
        return r;
    endfunction

endpackage

[hw/rtl/mccd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mccd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/min_coin_change_dp_top.sv]
// Top level of the minimum-coin change engine: handshakes, sequencer and table memories.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_data write target_amount; cfg_ready is always high.
//   Write it only while the block is idle.
//   s_* beats carry in_t. action 0 loads one coin (at most MAX_COINS per set,
//   extra loads are dropped); a load with last_coin set starts the fill and
//   produces one m_* beat of kind 0 for the target. action 1 looks up one
//   amount and always produces one beat of kind 1.
//   A lookup passes ST_LK_DATA and ST_EMIT into the output register (only
//   ST_EMIT above the last target). A fill walks amounts 1 to T, T the clamped
//   target, with N the coins in the set: per amount, N coin issues, a drain of
//   the two read stages, one write (only the write with no coins).
//   s_ready is high only while the sequencer is idle. A result waits in a
//   holding register until the output register is free, so a stalled m_ready
//   holds the block after it has finished the current item.
//   Reset (aresetn low, synchronous) empties the coin set, zeroes the target
//   and drops any pending beat. The tables need no clearing pass; amounts above
//   the last solved target read as unreachable.
module min_coin_change_dp_top #(
    parameter int MAX_TARGET = 1024,
    parameter int MAX_COINS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mccd_pkg::CV_W-1:0]           cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mccd_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mccd_pkg::out_t                      m_data
);

    import mccd_pkg::*;

    localparam int TA_W  = $clog2(MAX_TARGET);
    localparam int CA_W  = $clog2(MAX_COINS);
    localparam int CNT_W = $clog2(MAX_COINS + 1);
    localparam int XW    = (TA_W > CV_W) ? TA_W : CV_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ISSUE,
        ST_DRAIN,
        ST_WRITE,
        ST_LK_DATA,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [CV_W-1:0]   tgt_cfg_reg, tgt_cfg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [TA_W-1:0]   targ_reg, targ_next;
    logic [TA_W-1:0]   amt_reg, amt_next;
    logic [TA_W-1:0]   solved_reg, solved_next;
    logic [BEST_W-1:0] cur_reg, cur_next;
    logic [CV_W-1:0]   used_reg, used_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              s2_valid_reg, s2_valid_next;
    logic [CV_W-1:0]   s2_coin_reg, s2_coin_next;
    out_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    // coin memory
    logic              coin_we;
    logic [CA_W-1:0]   coin_waddr;
    logic [CA_W-1:0]   coin_raddr;
    logic [CV_W-1:0]   coin_rdata;

    // count/used table memory
    logic              tbl_we;
    logic [TA_W-1:0]   tbl_waddr;
    tbl_entry_t        tbl_wdata;
    logic [TA_W-1:0]   tbl_raddr;
    logic [TBL_W-1:0]  tbl_rdata_raw;
    tbl_entry_t        tbl_rdata;

    logic              s_fire;
    logic              s1_ok;
    logic [BEST_W-1:0] cand;
    logic [TA_W-1:0]   targ_clamped;
    logic              q_in_range;
    tbl_entry_t        cur_entry;
    tbl_entry_t        zero_entry;
    tbl_entry_t        origin_entry;

    mccd_ram #(.WIDTH(CV_W), .DEPTH(MAX_COINS)) u_coin_ram (
        .aclk  (aclk),
        .we    (coin_we),
        .waddr (coin_waddr),
        .wdata (s_data.coin_value),
        .raddr (coin_raddr),
        .rdata (coin_rdata)
    );

    mccd_ram #(.WIDTH(TBL_W), .DEPTH(MAX_TARGET)) u_tbl_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata_raw)
    );

    assign tbl_rdata = tbl_entry_t'(tbl_rdata_raw);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign targ_clamped = (32'(tgt_cfg_reg) >= 32'(MAX_TARGET)) ?
                          TA_W'(MAX_TARGET - 1) : TA_W'(tgt_cfg_reg);
    assign q_in_range   = (32'(s_data.query_amount) < 32'(MAX_TARGET)) &&
                          (32'(s_data.query_amount) <= 32'(solved_reg));

    assign coin_we    = s_fire && (s_data.action == ACT_LOAD) &&
                        (cnt_reg < CNT_W'(MAX_COINS));
    assign coin_waddr = cnt_reg[CA_W-1:0];
    assign coin_raddr = k_reg[CA_W-1:0];

    // stage 1: coin word is back, fetch the entry for amt - coin
    assign s1_ok     = (coin_rdata != '0) && (XW'(coin_rdata) <= XW'(amt_reg));
    assign tbl_raddr = (state_reg == ST_IDLE) ? TA_W'(s_data.query_amount) :
                       TA_W'(XW'(amt_reg) - XW'(coin_rdata));

    // stage 2: compare against the running best for this amount
    assign cand = tbl_rdata.best + BEST_W'(1);

    assign cur_entry    = '{best: cur_reg, used: used_reg};
    assign zero_entry   = '{best: '0, used: '0};
    assign origin_entry = '{best: BEST_W'(1), used: '0};

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = amt_reg;
        tbl_wdata = cur_entry;
        if (state_reg == ST_INIT) begin
            tbl_we    = 1'b1;
            tbl_waddr = '0;
            tbl_wdata = origin_entry;
        end else if (state_reg == ST_WRITE) begin
            tbl_we = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        tgt_cfg_next  = tgt_cfg_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        targ_next     = targ_reg;
        amt_next      = amt_reg;
        solved_next   = solved_reg;
        cur_next      = cur_reg;
        used_next     = used_reg;
        res_next      = res_reg;
        s1_valid_next = (state_reg == ST_ISSUE);
        s2_valid_next = s1_valid_reg && s1_ok;
        s2_coin_next  = coin_rdata;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        if (cfg_valid && cfg_ready) begin
            tgt_cfg_next = cfg_data;
        end

        if (s2_valid_reg && (tbl_rdata.best != '0) &&
            ((cur_reg == '0) || (cand < cur_reg))) begin
            cur_next  = cand;
            used_next = s2_coin_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.action == ACT_LOOKUP) begin
                        if (q_in_range) begin
                            state_next = ST_LK_DATA;
                        end else begin
                            res_next   = make_result(KIND_LOOKUP, zero_entry);
                            state_next = ST_EMIT;
                        end
                    end else begin
                        if (coin_we) begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        if (s_data.last_coin) begin
                            targ_next  = targ_clamped;
                            state_next = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT: begin
                solved_next = targ_reg;
                amt_next    = TA_W'(1);
                k_next      = '0;
                cur_next    = '0;
                used_next   = '0;
                if (targ_reg == '0) begin
                    res_next   = make_result(KIND_TARGET, origin_entry);
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    state_next = (cnt_reg == '0) ? ST_WRITE : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                k_next = k_reg + CNT_W'(1);
                if (CNT_W'(k_reg + CNT_W'(1)) == cnt_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!s1_valid_reg && !s2_valid_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (amt_reg == targ_reg) begin
                    res_next   = make_result(KIND_TARGET, cur_entry);
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    amt_next   = amt_reg + TA_W'(1);
                    k_next     = '0;
                    cur_next   = '0;
                    used_next  = '0;
                    state_next = (cnt_reg == '0) ? ST_WRITE : ST_ISSUE;
                end
            end
            ST_LK_DATA: begin
                res_next   = make_result(KIND_LOOKUP, tbl_rdata);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tgt_cfg_reg  <= '0;
            cnt_reg      <= '0;
            solved_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tgt_cfg_reg  <= tgt_cfg_next;
            cnt_reg      <= cnt_next;
            solved_reg   <= solved_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        k_reg       <= k_next;
        targ_reg    <= targ_next;
        amt_reg     <= amt_next;
        cur_reg     <= cur_next;
        used_reg    <= used_next;
        s2_coin_reg <= s2_coin_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

endmodule
